// ===== design/dtsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtsp_pkg: shared types and constants of the date-time string parser
// Field stage codes, character codes and date field digit limits.
// ----------------------------------------------------------------------------
package dtsp_pkg;

    // Field being parsed; STAGE_DONE once all seven fields have closed
    typedef enum logic [2:0] {
        STAGE_YEAR   = 3'd0,
        STAGE_MONTH  = 3'd1,
        STAGE_DAY    = 3'd2,
        STAGE_HOUR   = 3'd3,
        STAGE_MINUTE = 3'd4,
        STAGE_SECOND = 3'd5,
        STAGE_MILLIS = 3'd6,
        STAGE_DONE   = 3'd7
    } stage_t;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_PERIOD = 8'h2E;

    // Digits a date field holds before the next digit opens a new field
    localparam logic [2:0] YEAR_DIGITS = 3'd4;
    localparam logic [2:0] PART_DIGITS = 3'd2;

endpackage

// ===== design/dtsp_char_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtsp_char_if: character stream channel
// One byte of the date-time string per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dtsp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

// ===== design/dtsp_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtsp_result_if: parsed date-time channel
// All seven field values and the field count per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dtsp_result_if;
    logic        valid;
    logic        ready;
    logic [13:0] year_value;
    logic [6:0]  month_value;
    logic [6:0]  day_value;
    logic [29:0] hour_value;
    logic [29:0] minute_value;
    logic [29:0] second_value;
    logic [29:0] millis_value;
    logic [2:0]  fields_done;

    modport source (
        output valid, output year_value, output month_value, output day_value,
        output hour_value, output minute_value, output second_value,
        output millis_value, output fields_done, input ready
    );
    modport sink (
        input valid, input year_value, input month_value, input day_value,
        input hour_value, input minute_value, input second_value,
        input millis_value, input fields_done, output ready
    );
endinterface

// ===== design/datetime_string_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datetime_string_parser_unit: streaming date-time string parser
// Parses year, month, day, hour, minute, second and millisecond from a byte
// stream and emits one beat with all values when the zero byte arrives.
// ----------------------------------------------------------------------------
// The parser takes one character per clock on the text channel while the result
// channel is not stalled. Each beat updates the field state in a single pass:
// a decimal multiply-by-ten-and-add into the accumulator, a saturating compare
// for time fields and a stage advance. A zero byte closes the current field
// and loads all seven values into the output register, from where they are
// offered on the parsed channel in the next cycle; the parser state clears in
// the same cycle as that load, so the next string may start at once. Text beats
// are refused only while a finished result sits in the output register and the
// sink is not taking it. Date fields hold at most four (year) or two (month,
// day) digits; time fields saturate at TIME_SATURATE.
// ----------------------------------------------------------------------------
module datetime_string_parser_unit #(
    parameter int TIME_SATURATE = 999999999
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dtsp_char_if.sink             text,
    dtsp_result_if.source         parsed
);

    localparam logic [29:0] SAT_LIMIT = TIME_SATURATE[29:0];

    // Parser state
    dtsp_pkg::stage_t stage_reg, stage_next;
    logic [2:0]       count_reg, count_next;
    logic [29:0]      acc_reg, acc_next;
    logic [13:0]      year_reg, year_next;
    logic [6:0]       month_reg, month_next;
    logic [6:0]       day_reg, day_next;
    logic [29:0]      hour_reg, hour_next;
    logic [29:0]      minute_reg, minute_next;
    logic [29:0]      second_reg, second_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    logic [13:0]      out_year_reg, out_year_next;
    logic [6:0]       out_month_reg, out_month_next;
    logic [6:0]       out_day_reg, out_day_next;
    logic [29:0]      out_hour_reg, out_hour_next;
    logic [29:0]      out_minute_reg, out_minute_next;
    logic [29:0]      out_second_reg, out_second_next;
    logic [29:0]      out_millis_reg, out_millis_next;
    logic [2:0]       out_fields_reg, out_fields_next;

    // Decode of the incoming character
    logic        in_fire;
    logic        is_digit;
    logic        is_sep;
    logic        is_end;
    logic [7:0]  digit_diff;
    logic [3:0]  digit;
    logic [2:0]  stage_inc;
    logic [2:0]  date_limit;
    logic [13:0] date_mac;
    logic [33:0] time_mac;

    // Accept a text beat whenever the output register is free or draining
    assign text.ready = !out_valid_reg || parsed.ready;
    assign in_fire    = text.valid && text.ready;

    assign is_digit   = (text.character >= dtsp_pkg::CHAR_ZERO)
                     && (text.character <= dtsp_pkg::CHAR_NINE);
    assign is_end     = (text.character == dtsp_pkg::CHAR_NUL);
    assign is_sep     = (text.character == dtsp_pkg::CHAR_COLON)
                     || (text.character == dtsp_pkg::CHAR_PERIOD) || is_end;
    assign digit_diff = text.character - dtsp_pkg::CHAR_ZERO;
    assign digit      = is_digit ? digit_diff[3:0] : 4'd0;

    assign stage_inc  = stage_reg + 3'd1;
    assign date_limit = (stage_reg == dtsp_pkg::STAGE_YEAR) ? dtsp_pkg::YEAR_DIGITS
                                                            : dtsp_pkg::PART_DIGITS;

    // A date accumulator holds at most three digits when another is appended
    assign date_mac = {acc_reg[10:0], 3'b000} + {acc_reg[12:0], 1'b0}
                    + {10'd0, digit};
    assign time_mac = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {30'd0, digit};

    always_comb
    begin
        stage_next      = stage_reg;
        count_next      = count_reg;
        acc_next        = acc_reg;
        year_next       = year_reg;
        month_next      = month_reg;
        day_next        = day_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        second_next     = second_reg;

        out_valid_next  = out_valid_reg && !parsed.ready;
        out_year_next   = out_year_reg;
        out_month_next  = out_month_reg;
        out_day_next    = out_day_reg;
        out_hour_next   = out_hour_reg;
        out_minute_next = out_minute_reg;
        out_second_next = out_second_reg;
        out_millis_next = out_millis_reg;
        out_fields_next = out_fields_reg;

        if (in_fire)
        begin
            if (stage_reg <= dtsp_pkg::STAGE_DAY)
            begin
                // Date field: a non-digit or one digit too many closes it
                if (is_digit && (count_reg < date_limit))
                begin
                    acc_next   = {16'd0, date_mac};
                    count_next = count_reg + 3'd1;
                end
                else
                begin
                    case (stage_reg)
                        dtsp_pkg::STAGE_YEAR:  year_next  = acc_reg[13:0];
                        dtsp_pkg::STAGE_MONTH: month_next = acc_reg[6:0];
                        default:               day_next   = acc_reg[6:0];
                    endcase
                    stage_next = dtsp_pkg::stage_t'(stage_inc);
                    // The overflowing digit opens the next field
                    acc_next   = {26'd0, digit};
                    count_next = is_digit ? 3'd1 : 3'd0;
                end
            end
            else if (stage_reg != dtsp_pkg::STAGE_DONE)
            begin
                if (is_digit)
                begin
                    acc_next = (time_mac > {4'd0, SAT_LIMIT}) ? SAT_LIMIT : time_mac[29:0];
                end
                else if (is_sep)
                begin
                    case (stage_reg)
                        dtsp_pkg::STAGE_HOUR:   hour_next   = acc_reg;
                        dtsp_pkg::STAGE_MINUTE: minute_next = acc_reg;
                        dtsp_pkg::STAGE_SECOND: second_next = acc_reg;
                        default:                ;
                    endcase
                    // The millisecond value stays in the accumulator
                    if (stage_reg != dtsp_pkg::STAGE_MILLIS)
                    begin
                        acc_next = 30'd0;
                    end
                    count_next = 3'd0;
                    stage_next = dtsp_pkg::stage_t'(stage_inc);
                end
            end

            if (is_end)
            begin
                // Load the result beat from the updated fields, then clear
                out_valid_next  = 1'b1;
                out_year_next   = year_next;
                out_month_next  = month_next;
                out_day_next    = day_next;
                out_hour_next   = hour_next;
                out_minute_next = minute_next;
                out_second_next = second_next;
                out_millis_next = (stage_next == dtsp_pkg::STAGE_DONE) ? acc_next : 30'd0;
                out_fields_next = stage_next;

                stage_next  = dtsp_pkg::STAGE_YEAR;
                count_next  = 3'd0;
                acc_next    = 30'd0;
                year_next   = 14'd0;
                month_next  = 7'd0;
                day_next    = 7'd0;
                hour_next   = 30'd0;
                minute_next = 30'd0;
                second_next = 30'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= dtsp_pkg::STAGE_YEAR;
            count_reg     <= 3'd0;
            acc_reg       <= 30'd0;
            year_reg      <= 14'd0;
            month_reg     <= 7'd0;
            day_reg       <= 7'd0;
            hour_reg      <= 30'd0;
            minute_reg    <= 30'd0;
            second_reg    <= 30'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stage_reg     <= stage_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: held while a beat waits, no reset needed
    always_ff @(posedge clk)
    begin
        out_year_reg   <= out_year_next;
        out_month_reg  <= out_month_next;
        out_day_reg    <= out_day_next;
        out_hour_reg   <= out_hour_next;
        out_minute_reg <= out_minute_next;
        out_second_reg <= out_second_next;
        out_millis_reg <= out_millis_next;
        out_fields_reg <= out_fields_next;
    end

    assign parsed.valid        = out_valid_reg;
    assign parsed.year_value   = out_year_reg;
    assign parsed.month_value  = out_month_reg;
    assign parsed.day_value    = out_day_reg;
    assign parsed.hour_value   = out_hour_reg;
    assign parsed.minute_value = out_minute_reg;
    assign parsed.second_value = out_second_reg;
    assign parsed.millis_value = out_millis_reg;
    assign parsed.fields_done  = out_fields_reg;

    // A terminating beat leaves the parser cleared for the next string
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_end) |=> (stage_reg == dtsp_pkg::STAGE_YEAR) && (acc_reg == 30'd0)
                                && out_valid_reg)
        else $error("parser state not cleared after terminating beat");

    // Time accumulators never pass the saturation limit
    a_time_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg >= dtsp_pkg::STAGE_HOUR) |-> (acc_reg <= SAT_LIMIT))
        else $error("time accumulator above saturation limit");

    // Date digit count stays within the year field width
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dtsp_pkg::YEAR_DIGITS)
        else $error("date digit count out of range");

    // Text is refused only while a result is stalled in the output register
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !text.ready |-> (out_valid_reg && !parsed.ready))
        else $error("text refused without a stalled result");

    // A millisecond value appears only once all seven fields have closed
    a_millis_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_millis_reg != 30'd0))
            |-> (out_fields_reg == dtsp_pkg::STAGE_DONE))
        else $error("millisecond value present before all fields closed");

endmodule
